// File: rtl/ctrq_pkg.sv
// Shared types, codes and constants for the credit-throttled request queue.
`timescale 1ns / 1ps

package ctrq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int FUNC_W     = 2;
    localparam int ID_W       = 4;
    localparam int TICKS_W    = 16;
    localparam int MASK_W     = 16;
    localparam int NODE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int QCOUNT_W   = 5;
    localparam int BUDGET_W   = 16;
    localparam int DECAY_W    = 10;
    localparam int PROD_W     = TICKS_W + DECAY_W;
    localparam int COST_W     = 8;
    localparam int BAND_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [BUDGET_W-1:0] BUSY_THRESHOLD_RST = BUDGET_W'(17);
    localparam logic [DECAY_W-1:0]  DECAY_PER_TICK_RST = DECAY_W'(250);
    localparam logic [BUDGET_W-1:0] BUDGET_MAX         = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PER_TICK = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHARGE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_GRANT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CHARGED   = 3'd5;

    localparam int NUM_BANDS = 17;
    localparam int BAND_STEP = 10;

    localparam logic [COST_W-1:0] CHARGE_COST [NUM_BANDS] = '{
        8'd2, 8'd4, 8'd8, 8'd13, 8'd19, 8'd26, 8'd34, 8'd43, 8'd53,
        8'd64, 8'd76, 8'd89, 8'd103, 8'd118, 8'd134, 8'd151, 8'd169
    };

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ID_W-1:0]    requester_id;
        logic [TICKS_W-1:0] elapsed_ticks;
        logic [MASK_W-1:0]  live_mask;
        logic [NODE_W-1:0]  node_count;
    } t_cmd;

    typedef struct packed {
        logic                grant_valid;
        logic [ID_W-1:0]     grant_id;
        logic [STATUS_W-1:0] status;
        logic [QCOUNT_W-1:0] queue_count;
        logic [BUDGET_W-1:0] budget_level;
    } t_result;

    typedef struct packed {
        logic load_product;
        logic apply_decay;
        logic apply_charge;
    } t_budget_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REQ,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_TICK_MUL,
        S_TICK_SUB,
        S_TICK_CHK,
        S_TICK_CMP,
        S_CHARGE,
        S_DONE
    } t_state;

    // Band is (nodes - 1) / 10 above ten nodes, capped at the last band.
    function automatic logic [COST_W-1:0] charge_cost(input logic [NODE_W-1:0] nodes);
        logic [BAND_W-1:0] band;
        band = '0;
        for (int k = 1; k < NUM_BANDS; k++) begin
            if (nodes >= NODE_W'(BAND_STEP * k + 1)) begin
                band = BAND_W'(k);
            end
        end
        return CHARGE_COST[band];
    endfunction

endpackage

// File: rtl/credit_throttled_request_queue.sv
// Top level: sequencer for requests, ticks and charges over the ring and budget unit.
// A request decides a grant or full drop in S_REQ, else scans waiting ids and appends it
// if new; a charge runs S_CHARGE; a tick decays the budget, then pops heads while it is
// low and the queue not empty, dropping dead ones and granting a live one. One item at a
// time; busy stays high until the result cycle, when the next transaction may be accepted.
// Reset: synchronous active low; empties the queue, zeroes the budget and restores
// busy_threshold 17 and decay_per_tick 250. Results are never stalled by the receiver.
`timescale 1ns / 1ps

module credit_throttled_request_queue
    import ctrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    input  t_cmd                  i_cmd,
    output logic                  busy,
    output logic                  o_done,
    output t_result               o_result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_state r_state, n_state;

    t_cmd                r_cmd, n_cmd;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_gvalid, n_gvalid;
    logic [ID_W-1:0]     r_gid, n_gid;
    logic [STATUS_W-1:0] r_status, n_status;
    t_result             r_result, n_result;
    logic                r_done, n_done;

    logic [BUDGET_W-1:0] r_busy_threshold;
    logic [DECAY_W-1:0]  r_decay_per_tick;

    t_budget_ctl         budget_ctl;
    logic [BUDGET_W-1:0] budget;
    logic                budget_low;

    logic                ring_wr_en;
    logic                ring_rd_en;
    logic [IDX_W-1:0]    ring_rd_addr;
    logic [ID_W-1:0]     ring_rd_data;

    logic                accept;

    assign accept = start && (r_state == S_IDLE);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    ctrq_ring #(
        .DEPTH(QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (r_cmd.requester_id),
        .i_rd_en   (ring_rd_en),
        .i_rd_addr (ring_rd_addr),
        .o_rd_data (ring_rd_data)
    );

    ctrq_budget u_budget (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (budget_ctl),
        .i_elapsed_ticks  (r_cmd.elapsed_ticks),
        .i_decay_per_tick (r_decay_per_tick),
        .i_node_count     (r_cmd.node_count),
        .i_busy_threshold (r_busy_threshold),
        .o_budget         (budget),
        .o_low            (budget_low)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.func)
                        FUNC_REQUEST: n_state = S_REQ;
                        FUNC_TICK:    n_state = S_TICK_MUL;
                        FUNC_CHARGE:  n_state = S_CHARGE;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_REQ: begin
                if ((budget_low && r_count == '0) || r_count >= FULL_CNT) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD:  n_state = (r_idx == r_count) ? S_DONE : S_SCAN_CMP;
            S_SCAN_CMP: n_state = (ring_rd_data == r_cmd.requester_id) ? S_DONE : S_SCAN_RD;
            S_TICK_MUL: n_state = S_TICK_SUB;
            S_TICK_SUB: n_state = S_TICK_CHK;
            S_TICK_CHK: n_state = (budget_low && r_count != '0) ? S_TICK_CMP : S_DONE;
            S_TICK_CMP: n_state = r_cmd.live_mask[ring_rd_data] ? S_DONE : S_TICK_CHK;
            S_CHARGE:   n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and control
    always_comb begin
        n_cmd        = r_cmd;
        n_head       = r_head;
        n_pos        = r_pos;
        n_count      = r_count;
        n_idx        = r_idx;
        n_gvalid     = r_gvalid;
        n_gid        = r_gid;
        n_status     = r_status;
        n_result     = r_result;
        n_done       = 1'b0;
        budget_ctl   = '0;
        ring_wr_en   = 1'b0;
        ring_rd_en   = 1'b0;
        ring_rd_addr = r_pos;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_gvalid = 1'b0;
                    n_gid    = '0;
                    n_status = ST_NO_GRANT;
                end
            end
            S_REQ: begin
                n_pos = r_head;
                n_idx = '0;
                if (budget_low && r_count == '0) begin
                    n_gvalid = 1'b1;
                    n_gid    = r_cmd.requester_id;
                    n_status = ST_GRANTED;
                end else if (r_count >= FULL_CNT) begin
                    n_status = ST_FULL;
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_count) begin
                    // no match: append at the tail
                    ring_wr_en = 1'b1;
                    n_count    = r_count + 1'b1;
                    n_status   = ST_QUEUED;
                end else begin
                    ring_rd_en = 1'b1;
                end
            end
            S_SCAN_CMP: begin
                if (ring_rd_data == r_cmd.requester_id) begin
                    n_status = ST_DUPLICATE;
                end else begin
                    n_pos = ring_next(r_pos);
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TICK_MUL: budget_ctl.load_product = 1'b1;
            S_TICK_SUB: budget_ctl.apply_decay  = 1'b1;
            S_TICK_CHK: begin
                ring_rd_addr = r_head;
                ring_rd_en   = budget_low && r_count != '0;
            end
            S_TICK_CMP: begin
                // pop the head; grant it if still live, else drop and retry
                n_head  = ring_next(r_head);
                n_count = r_count - 1'b1;
                if (r_cmd.live_mask[ring_rd_data]) begin
                    n_gvalid = 1'b1;
                    n_gid    = ring_rd_data;
                    n_status = ST_GRANTED;
                end
            end
            S_CHARGE: begin
                budget_ctl.apply_charge = 1'b1;
                n_status                = ST_CHARGED;
            end
            S_DONE: begin
                n_result.grant_valid  = r_gvalid;
                n_result.grant_id     = r_gid;
                n_result.status       = r_status;
                n_result.queue_count  = QCOUNT_W'(r_count);
                n_result.budget_level = budget;
                n_done                = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_gvalid <= n_gvalid;
        r_gid    <= n_gid;
        r_status <= n_status;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_threshold <= BUSY_THRESHOLD_RST;
            r_decay_per_tick <= DECAY_PER_TICK_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BUSY_THRESHOLD: r_busy_threshold <= i_cfg_data[BUDGET_W-1:0];
                CFG_DECAY_PER_TICK: r_decay_per_tick <= i_cfg_data[DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count exceeds depth");

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_wr_en |-> (r_count < FULL_CNT))
        else $error("ring written while full");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("more than one result strobe for one transaction");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.grant_valid) |-> (o_result.status == ST_GRANTED))
        else $error("grant reported with non-grant status");

endmodule

// File: rtl/ctrq_ring.sv
// Ring storage for waiting requester ids: one write port, one registered read port.
`timescale 1ns / 1ps

module ctrq_ring
    import ctrq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [ID_W-1:0]          i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [ID_W-1:0]          o_rd_data
);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ctrq_budget.sv
// Credit budget register with its multiply, decay and charge arithmetic.
`timescale 1ns / 1ps

module ctrq_budget
    import ctrq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_budget_ctl         i_ctl,
    input  logic [TICKS_W-1:0]  i_elapsed_ticks,
    input  logic [DECAY_W-1:0]  i_decay_per_tick,
    input  logic [NODE_W-1:0]   i_node_count,
    input  logic [BUDGET_W-1:0] i_busy_threshold,
    output logic [BUDGET_W-1:0] o_budget,
    output logic                o_low
);

    logic [BUDGET_W-1:0] r_budget;
    logic [BUDGET_W-1:0] n_budget;
    logic [PROD_W-1:0]   r_product;
    logic [BUDGET_W:0]   charge_sum;

    assign charge_sum = {1'b0, r_budget} + (BUDGET_W + 1)'(charge_cost(i_node_count));

    always_comb begin
        n_budget = r_budget;
        if (i_ctl.apply_decay) begin
            // floor at zero
            if (r_product >= PROD_W'(r_budget)) begin
                n_budget = '0;
            end else begin
                n_budget = r_budget - r_product[BUDGET_W-1:0];
            end
        end else if (i_ctl.apply_charge) begin
            n_budget = charge_sum[BUDGET_W] ? BUDGET_MAX : charge_sum[BUDGET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_product) begin
            r_product <= PROD_W'(i_elapsed_ticks) * PROD_W'(i_decay_per_tick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= '0;
        end else begin
            r_budget <= n_budget;
        end
    end

    assign o_budget = r_budget;
    assign o_low    = (r_budget <= i_busy_threshold);

endmodule
